FILE: src/assert_macros.svh
// Assertion macros used by the hash table top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/oaht_pkg.sv
// Package with the types, codes and constants of the hash table.
package oaht_pkg;

    localparam int TABLE_SLOTS = 1024;
    localparam int VALUE_BYTES = 8;
    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int CFG_W = 11;
    localparam int KEY_W = 64;
    localparam int VAL_W = 64;
    localparam int LEN_W = 4;

    typedef enum logic [1:0] {
        MARK_EMPTY   = 2'd0,
        MARK_LIVE    = 2'd1,
        MARK_DELETED = 2'd2
    } mark_t;

    typedef enum logic [1:0] {
        CMD_GET     = 2'd0,
        CMD_SET     = 2'd1,
        CMD_REMOVE  = 2'd2,
        CMD_UNKNOWN = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_LIMIT   = 2'd2,
        ST_DROPPED = 2'd3
    } status_t;

    localparam logic REG_SLOTS_IN_USE = 1'b0;
    localparam logic REG_MAX_ENTRIES  = 1'b1;

    typedef struct packed {
        logic [1:0]       mark;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [LEN_W-1:0] length;
    } entry_t;

endpackage

FILE: src/oaht_ifs.sv
// Handshake interfaces for the command and response channels.
interface oaht_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [63:0] lookup_key;
    logic [63:0] value_word;
    logic [3:0]  value_length;

    modport source (output valid, command, lookup_key, value_word, value_length,
                    input ready);
    modport sink (input valid, command, lookup_key, value_word, value_length,
                  output ready);
endinterface

interface oaht_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] read_value;
    logic [3:0]  read_length;
    logic [10:0] live_count;

    modport source (output valid, status, read_value, read_length, live_count,
                    input ready);
    modport sink (input valid, status, read_value, read_length, live_count,
                  output ready);
endinterface

FILE: src/open_addressing_hash_table.sv
// Top level of the open-addressing hash table with linear probing.
//
// Channel  Dir  Payload                                          Handshake
// req      in   command, lookup_key, value_word, value_length    valid/ready
// rsp      out  status, read_value, read_length, live_count      valid/ready
// wr_*     in   wr_index, wr_data                                wr_en
//
// An item runs through the hash steps and the bit-serial modulo, then a read
// and a check state per probed slot, and a done state to hand the result over.
// After reset and after every write of slots_in_use a clearing pass over all
// TABLE_SLOTS slots empties the memory; no item is accepted meanwhile.
// One item is worked on at a time; a new item is accepted while a finished
// result still waits in the output register.
`include "assert_macros.svh"

module open_addressing_hash_table (
    input  logic                      clk,
    input  logic                      rst_n,
    oaht_req_if.sink                  req,
    oaht_rsp_if.source                rsp,
    input  logic                      wr_en,
    input  logic                      wr_index,
    input  logic [oaht_pkg::CFG_W-1:0] wr_data
);

    localparam int SW = oaht_pkg::SLOT_W;
    localparam int CW = oaht_pkg::CFG_W;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_HASH, S_DIV, S_RD, S_CHK, S_DONE
    } state_t;

    state_t state_reg;

    // Configuration and counters.
    logic [CW-1:0] eff_reg;
    logic [CW-1:0] max_reg;
    logic [CW-1:0] live_reg;
    logic [CW-1:0] empty_reg;

    // Current item.
    logic [1:0]  cmd_reg;
    logic [63:0] key_reg;
    logic [63:0] val_reg;
    logic [3:0]  len_reg;

    // Hash, modulo and probe walk.
    logic [63:0]   hash_reg;
    logic [2:0]    step_reg;
    logic [5:0]    bit_reg;
    logic [CW-1:0] rem_reg;
    logic [SW-1:0] slot_reg;
    logic [CW-1:0] count_reg;
    logic [SW-1:0] clr_reg;

    // Pending result and output register.
    logic [1:0]  res_status_reg;
    logic [63:0] res_value_reg;
    logic [3:0]  res_length_reg;
    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [63:0] out_value_reg;
    logic [3:0]  out_length_reg;
    logic [CW-1:0] out_live_reg;

    // Slot memory: mark, key, value and length in one word.
    oaht_pkg::entry_t mem [oaht_pkg::TABLE_SLOTS];
    oaht_pkg::entry_t rd_reg;
    logic             mem_we;
    logic [SW-1:0]    mem_waddr;
    oaht_pkg::entry_t mem_wdata;

    logic [CW-1:0] eff_wr;
    logic [63:0]   hash_step;
    logic [CW:0]   rem_shift;
    logic [CW-1:0] rem_new;
    logic [3:0]    sat_len;
    logic [63:0]   val_mask;
    logic          probe_stop;
    logic [CW-1:0] slot_inc;
    logic          write_set;
    logic          write_del;

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.read_value = out_value_reg;
    assign rsp.read_length = out_length_reg;
    assign rsp.live_count = out_live_reg;

    // A slot count of zero acts as one; counts above the table saturate.
    always_comb
    begin
        if (wr_data == '0)
            eff_wr = CW'(1);
        else if (32'(wr_data) > oaht_pkg::TABLE_SLOTS)
            eff_wr = CW'(oaht_pkg::TABLE_SLOTS);
        else
            eff_wr = wr_data;
    end

    // One mixing step of the 64-bit integer hash per cycle.
    always_comb
    begin
        case (step_reg)
            3'd0: hash_step = (~hash_reg) + (hash_reg << 21);
            3'd1: hash_step = hash_reg ^ (hash_reg >> 24);
            3'd2: hash_step = hash_reg + (hash_reg << 3) + (hash_reg << 8);
            3'd3: hash_step = hash_reg ^ (hash_reg >> 14);
            3'd4: hash_step = hash_reg + (hash_reg << 2) + (hash_reg << 4);
            3'd5: hash_step = hash_reg ^ (hash_reg >> 28);
            3'd6: hash_step = hash_reg + (hash_reg << 31);
            default: hash_step = hash_reg;
        endcase
    end

    // Restoring division, one dividend bit per cycle from the top.
    always_comb
    begin
        rem_shift = {rem_reg, hash_reg[63]};
        if (rem_shift >= {1'b0, eff_reg})
            rem_new = CW'(rem_shift - {1'b0, eff_reg});
        else
            rem_new = CW'(rem_shift);
    end

    // Stored length saturates and bytes past it are kept as zero.
    always_comb
    begin
        sat_len = (32'(len_reg) > oaht_pkg::VALUE_BYTES) ?
                  4'(oaht_pkg::VALUE_BYTES) : len_reg;
        for (int b = 0; b < 8; b++)
            val_mask[b*8 +: 8] = (4'(b) < sat_len) ? 8'hFF : 8'h00;
    end

    assign probe_stop = (rd_reg.mark == oaht_pkg::MARK_EMPTY) || (rd_reg.key == key_reg);
    assign slot_inc = CW'(slot_reg) + CW'(1);

    // A set stores when the slot is not a fresh one beyond the entry limit.
    assign write_set = (state_reg == S_CHK) && probe_stop && (cmd_reg == oaht_pkg::CMD_SET)
                       && !((rd_reg.mark == oaht_pkg::MARK_EMPTY) && (live_reg >= max_reg));
    assign write_del = (state_reg == S_CHK) && probe_stop
                       && (cmd_reg == oaht_pkg::CMD_REMOVE)
                       && (rd_reg.mark == oaht_pkg::MARK_LIVE);

    always_comb
    begin
        mem_we = 1'b0;
        mem_waddr = slot_reg;
        mem_wdata = rd_reg;
        if (state_reg == S_CLEAR)
        begin
            mem_we = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else if (write_set)
        begin
            mem_we = 1'b1;
            mem_wdata.mark = oaht_pkg::MARK_LIVE;
            mem_wdata.key = key_reg;
            mem_wdata.value = val_reg & val_mask;
            mem_wdata.length = sat_len;
        end
        else if (write_del)
        begin
            mem_we = 1'b1;
            mem_wdata.mark = oaht_pkg::MARK_DELETED;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_reg <= mem[slot_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            eff_reg <= CW'(1021);
            max_reg <= CW'(680);
            live_reg <= '0;
            empty_reg <= CW'(1021);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // The done state reloads the output register itself.
            if (out_valid_reg && rsp.ready && (wr_en || (state_reg != S_DONE)))
                out_valid_reg <= 1'b0;

            // Configuration is to arrive only while idle, which the block does not
            // enforce; a slot count write empties the store through a new clearing pass.
            if (wr_en)
            begin
                if (wr_index == oaht_pkg::REG_SLOTS_IN_USE)
                begin
                    eff_reg <= eff_wr;
                    empty_reg <= eff_wr;
                    live_reg <= '0;
                    clr_reg <= '0;
                    state_reg <= S_CLEAR;
                end
                else
                    max_reg <= wr_data;
            end
            else
            begin
                case (state_reg)
                    S_CLEAR:
                    begin
                        clr_reg <= clr_reg + SW'(1);
                        if (clr_reg == SW'(oaht_pkg::TABLE_SLOTS - 1))
                            state_reg <= S_IDLE;
                    end
                    S_IDLE:
                    begin
                        if (req.valid)
                        begin
                            cmd_reg <= req.command;
                            key_reg <= req.lookup_key;
                            val_reg <= req.value_word;
                            len_reg <= req.value_length;
                            hash_reg <= req.lookup_key;
                            step_reg <= '0;
                            res_value_reg <= '0;
                            res_length_reg <= '0;
                            if (req.command == oaht_pkg::CMD_UNKNOWN)
                            begin
                                res_status_reg <= oaht_pkg::ST_MISSING;
                                state_reg <= S_DONE;
                            end
                            else if (req.command == oaht_pkg::CMD_SET
                                     && empty_reg <= CW'(1))
                            begin
                                res_status_reg <= oaht_pkg::ST_DROPPED;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                res_status_reg <= oaht_pkg::ST_MISSING;
                                state_reg <= S_HASH;
                            end
                        end
                    end
                    S_HASH:
                    begin
                        hash_reg <= hash_step;
                        step_reg <= step_reg + 3'd1;
                        if (step_reg == 3'd6)
                        begin
                            rem_reg <= '0;
                            bit_reg <= '0;
                            state_reg <= S_DIV;
                        end
                    end
                    S_DIV:
                    begin
                        rem_reg <= rem_new;
                        hash_reg <= {hash_reg[62:0], 1'b0};
                        bit_reg <= bit_reg + 6'd1;
                        if (bit_reg == 6'd63)
                        begin
                            slot_reg <= SW'(rem_new);
                            count_reg <= '0;
                            state_reg <= S_RD;
                        end
                    end
                    S_RD:
                    begin
                        state_reg <= S_CHK;
                    end
                    S_CHK:
                    begin
                        if (probe_stop)
                        begin
                            state_reg <= S_DONE;
                            case (cmd_reg)
                                oaht_pkg::CMD_GET:
                                begin
                                    if (rd_reg.mark == oaht_pkg::MARK_LIVE)
                                    begin
                                        res_status_reg <= oaht_pkg::ST_OK;
                                        res_value_reg <= rd_reg.value;
                                        res_length_reg <= rd_reg.length;
                                    end
                                end
                                oaht_pkg::CMD_SET:
                                begin
                                    if (write_set)
                                    begin
                                        res_status_reg <= oaht_pkg::ST_OK;
                                        if (rd_reg.mark == oaht_pkg::MARK_EMPTY)
                                        begin
                                            empty_reg <= empty_reg - CW'(1);
                                            live_reg <= live_reg + CW'(1);
                                        end
                                        else if (rd_reg.mark == oaht_pkg::MARK_DELETED)
                                            live_reg <= live_reg + CW'(1);
                                    end
                                    else
                                        res_status_reg <= oaht_pkg::ST_LIMIT;
                                end
                                oaht_pkg::CMD_REMOVE:
                                begin
                                    if (write_del)
                                    begin
                                        res_status_reg <= oaht_pkg::ST_OK;
                                        if (live_reg != '0)
                                            live_reg <= live_reg - CW'(1);
                                    end
                                end
                                default: ;
                            endcase
                        end
                        else if (count_reg + CW'(1) == eff_reg)
                        begin
                            // Every slot was visited without a stop.
                            if (cmd_reg == oaht_pkg::CMD_SET)
                                res_status_reg <= oaht_pkg::ST_DROPPED;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            count_reg <= count_reg + CW'(1);
                            slot_reg <= (slot_inc >= eff_reg) ? '0 : SW'(slot_inc);
                            state_reg <= S_RD;
                        end
                    end
                    S_DONE:
                    begin
                        if (!out_valid_reg || rsp.ready)
                        begin
                            out_valid_reg <= 1'b1;
                            out_status_reg <= res_status_reg;
                            out_value_reg <= res_value_reg;
                            out_length_reg <= res_length_reg;
                            out_live_reg <= live_reg;
                            state_reg <= S_IDLE;
                        end
                    end
                    default: state_reg <= S_IDLE;
                endcase
            end
        end
    end

    `ASSERT_IMP(a_live_bound, 1'b1, live_reg <= eff_reg)
    `ASSERT_IMP(a_empty_bound, 1'b1, empty_reg <= eff_reg)
    `ASSERT_IMP(a_write_state, mem_we, (state_reg == S_CLEAR) || (state_reg == S_CHK))
    `ASSERT_NXT(a_result_load, (state_reg == S_DONE) && !out_valid_reg && !wr_en, out_valid_reg)

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the open-addressing hash table.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 6000000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        oaht_pkg::status_t status;
        logic [63:0]       read_value;
        logic [3:0]        read_length;
        logic [10:0]       live_count;
    } reply_t;

    // One row of the directed table. The expected reply is used only when typed is set.
    typedef struct {
        logic [1:0]  command;
        logic [63:0] key;
        logic [63:0] value;
        logic [3:0]  length;
        bit          typed;
        reply_t      reply;
    } row_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic wr_index;
    logic [oaht_pkg::CFG_W-1:0] wr_data;

    oaht_req_if req_ch ();
    oaht_rsp_if rsp_ch ();

    open_addressing_hash_table u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Shadow copy of the table, kept in step with every accepted item.
    logic [1:0]  shadow_mark [oaht_pkg::TABLE_SLOTS];
    logic [63:0] shadow_key [oaht_pkg::TABLE_SLOTS];
    logic [63:0] shadow_value [oaht_pkg::TABLE_SLOTS];
    logic [3:0]  shadow_length [oaht_pkg::TABLE_SLOTS];
    int unsigned shadow_live;
    int unsigned shadow_empty;
    logic [10:0] cfg_slots;
    logic [10:0] cfg_max;

    reply_t pending_replies[$];

    int unsigned cycle_count;
    int unsigned mismatches;
    int unsigned items_sent;
    int unsigned replies_seen;
    int unsigned status_seen [4];
    bit          quiet_stretch;
    bit          hold_request;
    int unsigned hold_left;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, pending_replies.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int unsigned slot_count();
        int unsigned n;
        n = cfg_slots;
        if (n == 0)
            n = 1;
        if (n > oaht_pkg::TABLE_SLOTS)
            n = oaht_pkg::TABLE_SLOTS;
        return n;
    endfunction

    function automatic void clear_shadow();
        for (int i = 0; i < oaht_pkg::TABLE_SLOTS; i++)
        begin
            shadow_mark[i] = oaht_pkg::MARK_EMPTY;
            shadow_key[i] = '0;
            shadow_value[i] = '0;
            shadow_length[i] = '0;
        end
        shadow_live = 0;
        shadow_empty = slot_count();
    endfunction

    function automatic logic [63:0] key_mix(logic [63:0] k);
        k = (~k) + (k << 21);
        k = k ^ (k >> 24);
        k = (k + (k << 3)) + (k << 8);
        k = k ^ (k >> 14);
        k = (k + (k << 2)) + (k << 4);
        k = k ^ (k >> 28);
        k = k + (k << 31);
        return k;
    endfunction

    // Linear probe: stops at an empty slot or at a slot holding the key, live or deleted.
    function automatic bit find_slot(logic [63:0] key, output int unsigned slot);
        int unsigned n;
        int unsigned s;
        n = slot_count();
        s = int'(key_mix(key) % 64'(n));
        slot = 0;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (shadow_mark[s] == oaht_pkg::MARK_EMPTY || shadow_key[s] == key)
            begin
                slot = s;
                return 1'b1;
            end
            s = (s + 1 >= n) ? 0 : s + 1;
        end
        return 1'b0;
    endfunction

    function automatic reply_t table_command(logic [1:0] command, logic [63:0] key,
                                             logic [63:0] value, logic [3:0] length);
        reply_t      r;
        int unsigned slot;
        bit          hit;
        int unsigned len;
        r = '{status: oaht_pkg::ST_MISSING, read_value: '0, read_length: '0,
              live_count: '0};
        case (command)
            oaht_pkg::CMD_GET:
            begin
                hit = find_slot(key, slot);
                if (hit && shadow_mark[slot] == oaht_pkg::MARK_LIVE)
                begin
                    r.status = oaht_pkg::ST_OK;
                    r.read_value = shadow_value[slot];
                    r.read_length = shadow_length[slot];
                end
            end
            oaht_pkg::CMD_SET:
            begin
                if (shadow_empty <= 1)
                    r.status = oaht_pkg::ST_DROPPED;
                else if (!find_slot(key, slot))
                    r.status = oaht_pkg::ST_DROPPED;
                else if (shadow_mark[slot] == oaht_pkg::MARK_EMPTY && shadow_live >= cfg_max)
                    r.status = oaht_pkg::ST_LIMIT;
                else
                begin
                    len = (length > oaht_pkg::VALUE_BYTES) ? oaht_pkg::VALUE_BYTES : length;
                    if (len < 8)
                        value &= (64'h1 << (len * 8)) - 64'h1;
                    if (shadow_mark[slot] == oaht_pkg::MARK_EMPTY)
                    begin
                        shadow_empty--;
                        shadow_live++;
                    end
                    else if (shadow_mark[slot] == oaht_pkg::MARK_DELETED)
                        shadow_live++;
                    shadow_mark[slot] = oaht_pkg::MARK_LIVE;
                    shadow_key[slot] = key;
                    shadow_value[slot] = value;
                    shadow_length[slot] = 4'(len);
                    r.status = oaht_pkg::ST_OK;
                end
            end
            oaht_pkg::CMD_REMOVE:
            begin
                hit = find_slot(key, slot);
                if (hit && shadow_mark[slot] == oaht_pkg::MARK_LIVE)
                begin
                    shadow_mark[slot] = oaht_pkg::MARK_DELETED;
                    if (shadow_live > 0)
                        shadow_live--;
                    r.status = oaht_pkg::ST_OK;
                end
            end
            default:
                r.status = oaht_pkg::ST_MISSING;
        endcase
        r.live_count = 11'(shadow_live);
        return r;
    endfunction

    function automatic bit idle_roll();
        return !quiet_stretch && ($urandom_range(99) < 19);
    endfunction

    // Offers one item and waits for it to be taken. The expected reply is queued at
    // acceptance; a typed row replaces the shadow's reply with the one from the table.
    task automatic offer_item(logic [1:0] command, logic [63:0] key, logic [63:0] value,
                              logic [3:0] length, bit typed, reply_t typed_reply);
        reply_t r;
        while (idle_roll())
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.command <= command;
        req_ch.lookup_key <= key;
        req_ch.value_word <= value;
        req_ch.value_length <= length;
        do
            @(posedge clk);
        while (!req_ch.ready);
        r = table_command(command, key, value, length);
        pending_replies.push_back(typed ? typed_reply : r);
        items_sent++;
    endtask

    // Registers change only with the table idle: no item offered, every reply back.
    task automatic write_register(logic index, logic [10:0] data);
        req_ch.valid <= 1'b0;
        wait (pending_replies.size() == 0);
        repeat (4) @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= index;
        wr_data <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        if (index == oaht_pkg::REG_SLOTS_IN_USE)
        begin
            cfg_slots = data;
            clear_shadow();
        end
        else
            cfg_max = data;
    endtask

    // Mostly keys from a small pool so that hits, tombstones and revivals are common.
    task automatic random_phase(int unsigned count);
        logic [63:0] pool [12];
        logic [63:0] key;
        logic [1:0]  command;
        int unsigned roll;
        reply_t      none;
        none = '0;
        foreach (pool[i])
            pool[i] = {$urandom, $urandom};
        for (int unsigned n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 48)
                command = oaht_pkg::CMD_SET;
            else if (roll < 74)
                command = oaht_pkg::CMD_GET;
            else if (roll < 95)
                command = oaht_pkg::CMD_REMOVE;
            else
                command = oaht_pkg::CMD_UNKNOWN;
            key = ($urandom_range(99) < 85) ? pool[$urandom_range(11)] : {$urandom, $urandom};
            offer_item(command, key, {$urandom, $urandom}, 4'($urandom_range(15)), 1'b0, none);
        end
    endtask

    // Response side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        reply_t want;
        rsp_ch.ready = 1'b0;
        forever
        begin
            if (hold_request && hold_left == 0)
            begin
                hold_left = HOLD_OFF_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready <= !idle_roll();
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                replies_seen++;
                status_seen[rsp_ch.status]++;
                if (pending_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reply with nothing expected: status %0d", rsp_ch.status);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (rsp_ch.status !== want.status || rsp_ch.read_value !== want.read_value
                        || rsp_ch.read_length !== want.read_length
                        || rsp_ch.live_count !== want.live_count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: got st %0d val %h len %0d live %0d",
                                     rsp_ch.status, rsp_ch.read_value, rsp_ch.read_length,
                                     rsp_ch.live_count);
                            $display("         want st %0d val %h len %0d live %0d",
                                     want.status, want.read_value, want.read_length,
                                     want.live_count);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        row_t   rows [$];
        reply_t none;
        none = '0;
        cycle_count = 0;
        mismatches = 0;
        items_sent = 0;
        replies_seen = 0;
        status_seen = '{default: 0};
        quiet_stretch = 1'b0;
        hold_request = 1'b0;
        hold_left = 0;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = oaht_pkg::REG_SLOTS_IN_USE;
        wr_data = '0;
        req_ch.valid = 1'b0;
        req_ch.command = oaht_pkg::CMD_GET;
        req_ch.lookup_key = '0;
        req_ch.value_word = '0;
        req_ch.value_length = '0;
        cfg_slots = 11'd1021;
        cfg_max = 11'd680;
        clear_shadow();

        // Directed rows: empty table, extreme keys and values, length saturation and
        // masking, tombstones and revival, and the unknown command.
        rows = '{
            '{oaht_pkg::CMD_GET, 64'h0, 64'h0, 4'd0, 1'b1,
              '{oaht_pkg::ST_MISSING, 64'h0, 4'd0, 11'd0}},
            '{oaht_pkg::CMD_REMOVE, 64'h0, 64'h0, 4'd0, 1'b1,
              '{oaht_pkg::ST_MISSING, 64'h0, 4'd0, 11'd0}},
            '{oaht_pkg::CMD_SET, 64'h0, '1, 4'd8, 1'b1,
              '{oaht_pkg::ST_OK, 64'h0, 4'd0, 11'd1}},
            '{oaht_pkg::CMD_GET, 64'h0, 64'h0, 4'd0, 1'b1,
              '{oaht_pkg::ST_OK, '1, 4'd8, 11'd1}},
            '{oaht_pkg::CMD_SET, '1, '1, 4'd15, 1'b1,
              '{oaht_pkg::ST_OK, 64'h0, 4'd0, 11'd2}},
            '{oaht_pkg::CMD_GET, '1, 64'h0, 4'd0, 1'b1,
              '{oaht_pkg::ST_OK, '1, 4'd8, 11'd2}},
            '{oaht_pkg::CMD_SET, '1, '1, 4'd0, 1'b1,
              '{oaht_pkg::ST_OK, 64'h0, 4'd0, 11'd2}},
            '{oaht_pkg::CMD_GET, '1, 64'h0, 4'd0, 1'b1,
              '{oaht_pkg::ST_OK, 64'h0, 4'd0, 11'd2}},
            '{oaht_pkg::CMD_SET, 64'h8000_0000_0000_0001, 64'h1122_3344_5566_7788, 4'd3,
              1'b0, none},
            '{oaht_pkg::CMD_GET, 64'h8000_0000_0000_0001, 64'h0, 4'd0, 1'b0, none},
            '{oaht_pkg::CMD_SET, 64'h5555_AAAA_5555_AAAA, 64'hA5A5_5A5A_A5A5_5A5A, 4'd7,
              1'b0, none},
            '{oaht_pkg::CMD_GET, 64'h5555_AAAA_5555_AAAA, 64'h0, 4'd0, 1'b0, none},
            '{oaht_pkg::CMD_REMOVE, 64'h0, 64'h0, 4'd0, 1'b1,
              '{oaht_pkg::ST_OK, 64'h0, 4'd0, 11'd3}},
            '{oaht_pkg::CMD_GET, 64'h0, 64'h0, 4'd0, 1'b1,
              '{oaht_pkg::ST_MISSING, 64'h0, 4'd0, 11'd3}},
            '{oaht_pkg::CMD_REMOVE, 64'h0, 64'h0, 4'd0, 1'b1,
              '{oaht_pkg::ST_MISSING, 64'h0, 4'd0, 11'd3}},
            '{oaht_pkg::CMD_SET, 64'h0, 64'h1234, 4'd2, 1'b1,
              '{oaht_pkg::ST_OK, 64'h0, 4'd0, 11'd4}},
            '{oaht_pkg::CMD_GET, 64'h0, 64'h0, 4'd0, 1'b1,
              '{oaht_pkg::ST_OK, 64'h1234, 4'd2, 11'd4}},
            '{oaht_pkg::CMD_UNKNOWN, 64'h0, '1, 4'd15, 1'b1,
              '{oaht_pkg::ST_MISSING, 64'h0, 4'd0, 11'd4}},
            '{oaht_pkg::CMD_GET, 64'h0, 64'h0, 4'd0, 1'b1,
              '{oaht_pkg::ST_OK, 64'h1234, 4'd2, 11'd4}}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
            offer_item(rows[i].command, rows[i].key, rows[i].value, rows[i].length,
                       rows[i].typed, rows[i].reply);

        // Reset sizing: the block fills its output while the receiver holds off.
        hold_request = 1'b1;
        random_phase(110);
        req_ch.valid <= 1'b0;
        wait (pending_replies.size() == 0);

        // Small table with a tight limit: limit and drop statuses become frequent.
        write_register(oaht_pkg::REG_SLOTS_IN_USE, 11'd7);
        write_register(oaht_pkg::REG_MAX_ENTRIES, 11'd4);
        quiet_stretch = 1'b1;
        random_phase(60);
        quiet_stretch = 1'b0;

        // A three-slot table, no entries allowed, then no limit at all.
        write_register(oaht_pkg::REG_SLOTS_IN_USE, 11'd3);
        write_register(oaht_pkg::REG_MAX_ENTRIES, 11'd0);
        random_phase(20);
        write_register(oaht_pkg::REG_MAX_ENTRIES, 11'h7FF);
        random_phase(25);

        // A zero slot count acts as one slot, so every set is dropped.
        write_register(oaht_pkg::REG_SLOTS_IN_USE, 11'd0);
        write_register(oaht_pkg::REG_MAX_ENTRIES, 11'd5);
        random_phase(15);

        // Oversized slot count saturates to the full table.
        write_register(oaht_pkg::REG_SLOTS_IN_USE, 11'h7FF);
        write_register(oaht_pkg::REG_MAX_ENTRIES, 11'd1024);
        random_phase(55);

        write_register(oaht_pkg::REG_SLOTS_IN_USE, 11'd13);
        random_phase(60);

        write_register(oaht_pkg::REG_SLOTS_IN_USE, 11'd1024);
        write_register(oaht_pkg::REG_MAX_ENTRIES, 11'd2);
        random_phase(40);

        req_ch.valid <= 1'b0;
        wait (pending_replies.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d items sent, %0d replies checked over seven table sizings", items_sent,
                 replies_seen);
        $display("statuses: ok %0d, missing %0d, limit %0d, dropped %0d", status_seen[0],
                 status_seen[1], status_seen[2], status_seen[3]);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
